// ===== sv/paxos_proposer_engine_top_assert.svh =====
// assertion macros for the paxos proposer top level
// expects signals clk and rst in the including scope
`ifndef PAXOS_PROPOSER_ENGINE_TOP_ASSERT_SVH
`define PAXOS_PROPOSER_ENGINE_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define PAXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PAXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/paxp_pkg.sv =====
// shared types and constants of the paxos proposer engine
// no dependencies
package paxp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_QUORUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [4:0]  QUORUM_RST  = 5'd2;
  localparam logic [3:0]  OWN_RST     = 4'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd200;
  localparam logic [31:0] COUNTER_RST = 32'd2;
  localparam logic [15:0] TICKS_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_PROMISE = 3'd1,
    ACT_ACCEPT  = 3'd2,
    ACT_REJECT  = 3'd3,
    ACT_TICK    = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    KIND_PHASE1  = 3'd0,
    KIND_PHASE2  = 3'd1,
    KIND_COMMIT  = 3'd2,
    KIND_CATCHUP = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2,
    PH_PROC = 2'd3
  } phase_t;

  typedef struct packed {
    logic [4:0]  quorum;
    logic [3:0]  own_node;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] round;
    logic [63:0] value;
    logic [31:0] reply_number;
    logic [3:0]  reply_node;
    logic [3:0]  origin_node;
    logic        has_accepted;
    logic [31:0] accepted_number;
    logic [3:0]  accepted_node;
  } evt_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] msg_round;
    logic [31:0] msg_number;
    logic [3:0]  msg_node;
    logic [63:0] msg_value;
    logic        last;
  } res_t;

  // zero, one or two results produced by one event
  typedef struct packed {
    logic [1:0] count;
    res_t       item0;
    res_t       item1;
  } res_push_t;

endpackage

// ===== sv/paxp_evt_if.sv =====
// event channel: valid/ready handshake plus event fields
// no dependencies
interface paxp_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] round;
  logic [63:0] value;
  logic [31:0] reply_number;
  logic [3:0]  reply_node;
  logic [3:0]  origin_node;
  logic        has_accepted;
  logic [31:0] accepted_number;
  logic [3:0]  accepted_node;

  modport source (
    output valid, action, round, value, reply_number, reply_node, origin_node,
           has_accepted, accepted_number, accepted_node,
    input  ready
  );
  modport sink (
    input  valid, action, round, value, reply_number, reply_node, origin_node,
           has_accepted, accepted_number, accepted_node,
    output ready
  );
endinterface

// ===== sv/paxp_res_if.sv =====
// result channel: valid/ready handshake plus message fields
// no dependencies
interface paxp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] msg_round;
  logic [31:0] msg_number;
  logic [3:0]  msg_node;
  logic [63:0] msg_value;
  logic        last;

  modport source (
    output valid, kind, msg_round, msg_number, msg_node, msg_value, last,
    input  ready
  );
  modport sink (
    input  valid, kind, msg_round, msg_number, msg_node, msg_value, last,
    output ready
  );
endinterface

// ===== sv/paxp_core.sv =====
// proposer state and single-pass event evaluation
// depends on paxp_pkg
module paxp_core #(
  parameter int NODES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  paxp_pkg::evt_t        evt_in,
  input  paxp_pkg::cfg_t        cfg,
  output paxp_pkg::res_push_t   push
);
  import paxp_pkg::*;

  localparam int IDXW = $clog2(NODES);
  localparam int TW   = $clog2(NODES + 1);
  localparam int CW   = (TW > 5) ? TW : 5;

  // proposer state
  phase_t            phase, phase_next;
  logic [31:0]       counter, counter_next;
  logic [31:0]       cur_round, cur_round_next;
  logic [63:0]       own_value, own_value_next;
  logic [63:0]       chosen, chosen_next;
  logic [31:0]       best_number, best_number_next;
  logic [3:0]        best_node, best_node_next;
  logic [NODES-1:0]  promise_seen, promise_seen_next;
  logic [NODES-1:0]  accept_seen, accept_seen_next;
  logic [TW-1:0]     promise_tally, promise_tally_next;
  logic [TW-1:0]     accept_tally, accept_tally_next;
  logic [15:0]       elapsed, elapsed_next;

  // reply decode
  logic              reply_match;
  logic              origin_ok;
  logic [IDXW+3:0]   origin_wide;
  logic [NODES-1:0]  origin_bit;
  logic              better;
  logic [15:0]       ticks_inc;
  res_push_t         push_c;

  assign reply_match = (evt_in.reply_number == counter) &&
                       (evt_in.reply_node == cfg.own_node);
  assign origin_ok   = (32'(evt_in.origin_node) < NODES);
  assign origin_wide = (IDXW + 4)'(evt_in.origin_node);
  assign better      = evt_in.has_accepted &&
                       ((evt_in.accepted_number > best_number) ||
                        ((evt_in.accepted_number == best_number) &&
                         (evt_in.accepted_node > best_node)));
  assign ticks_inc   = (elapsed < TICKS_MAX) ? (elapsed + 16'd1) : elapsed;

  always_comb begin
    origin_bit = '0;
    if (origin_ok) begin
      origin_bit[origin_wide[IDXW-1:0]] = 1'b1;
    end
  end

  // next state and results for the event in the input register
  always_comb begin
    phase_next         = phase;
    counter_next       = counter;
    cur_round_next     = cur_round;
    own_value_next     = own_value;
    chosen_next        = chosen;
    best_number_next   = best_number;
    best_node_next     = best_node;
    promise_seen_next  = promise_seen;
    accept_seen_next   = accept_seen;
    promise_tally_next = promise_tally;
    accept_tally_next  = accept_tally;
    elapsed_next       = elapsed;
    push_c             = '0;

    unique case (evt_in.action)
      ACT_START: begin
        counter_next       = counter + 32'd1;
        promise_seen_next  = '0;
        accept_seen_next   = '0;
        promise_tally_next = '0;
        accept_tally_next  = '0;
        best_number_next   = '0;
        best_node_next     = '0;
        own_value_next     = evt_in.value;
        cur_round_next     = evt_in.round;
        phase_next         = PH_ONE;
        elapsed_next       = '0;
        push_c.count       = 2'd1;
        push_c.item0       = '{KIND_PHASE1, evt_in.round, counter_next,
                               cfg.own_node, 64'd0, 1'b1};
      end
      ACT_PROMISE: begin
        if ((phase == PH_ONE) && reply_match && origin_ok &&
            ((promise_seen & origin_bit) == '0)) begin
          promise_seen_next  = promise_seen | origin_bit;
          promise_tally_next = TW'(promise_tally + 1'b1);
          if (better) begin
            best_number_next = evt_in.accepted_number;
            best_node_next   = evt_in.accepted_node;
            chosen_next      = evt_in.value;
          end
          if (CW'(promise_tally_next) >= CW'(cfg.quorum)) begin
            if (best_number_next == 32'd0) begin
              chosen_next = own_value;
            end
            phase_next   = PH_TWO;
            elapsed_next = '0;
            push_c.count = 2'd1;
            push_c.item0 = '{KIND_PHASE2, cur_round, counter, cfg.own_node,
                             chosen_next, 1'b1};
          end
        end
      end
      ACT_ACCEPT: begin
        if ((phase == PH_TWO) && reply_match && origin_ok &&
            ((accept_seen & origin_bit) == '0)) begin
          accept_seen_next  = accept_seen | origin_bit;
          accept_tally_next = TW'(accept_tally + 1'b1);
          if (CW'(accept_tally_next) == CW'(cfg.quorum)) begin
            phase_next   = PH_PROC;
            elapsed_next = '0;
            push_c.count = 2'd2;
            push_c.item0 = '{KIND_COMMIT, cur_round, counter, cfg.own_node,
                             chosen, 1'b0};
            push_c.item1 = '{KIND_CATCHUP, cur_round, counter, cfg.own_node,
                             chosen, 1'b1};
          end
        end
      end
      ACT_REJECT: begin
        if ((phase == PH_ONE) && reply_match) begin
          phase_next   = PH_IDLE;
          elapsed_next = '0;
          push_c.count = 2'd1;
          push_c.item0 = '{KIND_CATCHUP, evt_in.round, counter, cfg.own_node,
                           evt_in.value, 1'b1};
        end
      end
      ACT_TICK: begin
        if ((phase == PH_ONE) || (phase == PH_TWO)) begin
          if (ticks_inc >= cfg.timeout_ticks) begin
            phase_next   = PH_IDLE;
            elapsed_next = '0;
            push_c.count = 2'd1;
            push_c.item0 = '{KIND_TIMEOUT, cur_round, counter, cfg.own_node,
                             64'd0, 1'b1};
          end else begin
            elapsed_next = ticks_inc;
          end
        end
      end
      default: begin
        // unknown action codes leave everything unchanged
      end
    endcase
  end

  assign push = go ? push_c : '0;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      counter       <= COUNTER_RST;
      cur_round     <= '0;
      own_value     <= '0;
      chosen        <= '0;
      best_number   <= '0;
      best_node     <= '0;
      promise_seen  <= '0;
      accept_seen   <= '0;
      promise_tally <= '0;
      accept_tally  <= '0;
      elapsed       <= '0;
    end else if (go) begin
      phase         <= phase_next;
      counter       <= counter_next;
      cur_round     <= cur_round_next;
      own_value     <= own_value_next;
      chosen        <= chosen_next;
      best_number   <= best_number_next;
      best_node     <= best_node_next;
      promise_seen  <= promise_seen_next;
      accept_seen   <= accept_seen_next;
      promise_tally <= promise_tally_next;
      accept_tally  <= accept_tally_next;
      elapsed       <= elapsed_next;
    end
  end

endmodule

// ===== sv/paxp_resq.sv =====
// four-entry result queue, up to two writes and one read per cycle
// depends on paxp_pkg and paxp_res_if
module paxp_resq (
  input  logic                 clk,
  input  logic                 rst,
  input  paxp_pkg::res_push_t  push,
  output logic                 space,
  paxp_res_if.source           res
);
  import paxp_pkg::*;

  res_t       q [4];
  logic [1:0] head, head_next;
  logic [1:0] tail, tail_next;
  logic [2:0] count, count_next;
  logic       pop;
  res_t       head_item;

  // room for a full two-result transaction
  assign space = (count <= 3'd2);
  assign pop   = res.valid && res.ready;

  assign head_next  = pop ? (head + 2'd1) : head;
  assign tail_next  = tail + push.count;
  assign count_next = count + 3'(push.count) - 3'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[tail] <= push.item0;
    end
    if (push.count == 2'd2) begin
      q[tail + 2'd1] <= push.item1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // head entry drives the result channel
  assign head_item      = q[head];
  assign res.valid      = (count != 3'd0);
  assign res.kind       = head_item.kind;
  assign res.msg_round  = head_item.msg_round;
  assign res.msg_number = head_item.msg_number;
  assign res.msg_node   = head_item.msg_node;
  assign res.msg_value  = head_item.msg_value;
  assign res.last       = head_item.last;

endmodule

// ===== sv/paxos_proposer_engine_top.sv =====
// a result is offered by the result queue after its event transaction has
// passed the event register; throughput: one event per cycle while the queue
// has room for two results, set by the single-pass evaluation behind the event
// register. events with two results share the one-per-cycle result port through
// a four-entry queue. reset: synchronous rst restores the configuration defaults,
// the proposer state and empties both the event register and the result queue.
module paxos_proposer_engine_top #(
  parameter int NODES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  paxp_evt_if.sink                       evt,
  paxp_res_if.source                     res,
  input  logic                           cfg_we,
  input  logic [paxp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [paxp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import paxp_pkg::*;

  cfg_t      cfg;
  evt_t      evt_q;
  logic      evt_q_valid;
  logic      space;
  logic      fire;
  res_push_t push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quorum        <= QUORUM_RST;
      cfg.own_node      <= OWN_RST;
      cfg.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUORUM:  cfg.quorum        <= cfg_wdata[4:0];
        CFG_OWN:     cfg.own_node      <= cfg_wdata[3:0];
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_wdata;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // event register, drained whenever the queue has room for two results
  assign fire      = evt_q_valid && space;
  assign evt.ready = !evt_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_q_valid <= 1'b0;
    end else if (evt.ready) begin
      evt_q_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      evt_q <= '{evt.action, evt.round, evt.value, evt.reply_number,
                 evt.reply_node, evt.origin_node, evt.has_accepted,
                 evt.accepted_number, evt.accepted_node};
    end
  end

  paxp_core #(
    .NODES (NODES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (fire),
    .evt_in (evt_q),
    .cfg    (cfg),
    .push   (push)
  );

  paxp_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (space),
    .res   (res)
  );

  // checks
  `include "paxos_proposer_engine_top_assert.svh"

  `PAXP_ASSERT_NEXT(a_evt_captured, evt.valid && evt.ready, evt_q_valid, "event transaction lost")
  `PAXP_ASSERT_NEXT(a_evt_held, evt_q_valid && !fire, evt_q_valid, "stalled event dropped")
  `PAXP_ASSERT_NOW(a_push_on_fire, push.count != 2'd0, fire && (push.count != 2'd3), "bad push")
  `PAXP_ASSERT_NEXT(a_push_visible, push.count != 2'd0, res.valid, "pushed result not offered")

endmodule

// ===== tb/sv/paxp_sb_pkg.sv =====
// scoreboard for the paxos proposer engine: proposer state tracker and message checker
// depends on paxp_pkg for the configuration, event and result types
package paxp_sb_pkg;
  import paxp_pkg::*;

  localparam int NODE_COUNT = 16;

  class proposer_tracker;
    cfg_t        cfg;
    phase_t      phase;
    logic [31:0] counter;
    logic [31:0] cur_round;
    logic [63:0] own_value;
    logic [63:0] chosen;
    logic [31:0] best_num;
    logic [3:0]  best_node;
    logic [15:0] promise_seen;
    logic [15:0] accept_seen;
    logic [4:0]  promise_tally;
    logic [4:0]  accept_tally;
    logic [15:0] elapsed;
    res_t        outgoing[$];
    int          errors;

    function new();
      cfg.quorum        = QUORUM_RST;
      cfg.own_node      = OWN_RST;
      cfg.timeout_ticks = TIMEOUT_RST;
      phase         = PH_IDLE;
      counter       = COUNTER_RST;
      cur_round     = '0;
      own_value     = '0;
      chosen        = '0;
      best_num      = '0;
      best_node     = '0;
      promise_seen  = '0;
      accept_seen   = '0;
      promise_tally = '0;
      accept_tally  = '0;
      elapsed       = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_QUORUM:  cfg.quorum = data[4:0];
        CFG_OWN:     cfg.own_node = data[3:0];
        CFG_TIMEOUT: cfg.timeout_ticks = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return outgoing.size();
    endfunction

    function bit is_ours(logic [31:0] num, logic [3:0] node);
      return num == counter && node == cfg.own_node;
    endfunction

    // every message carries the current proposal number and node
    function void send_msg(kind_t k, logic [31:0] rnd, logic [63:0] v, logic fin);
      res_t m;
      m.kind       = k;
      m.msg_round  = rnd;
      m.msg_number = counter;
      m.msg_node   = cfg.own_node;
      m.msg_value  = v;
      m.last       = fin;
      outgoing.push_back(m);
    endfunction

    // update the proposer for one accepted event; returns 0 if it was ignored
    function bit take_event(evt_t e);
      case (e.action)
        ACT_START: begin
          counter       = counter + 32'd1;
          promise_seen  = '0;
          accept_seen   = '0;
          promise_tally = '0;
          accept_tally  = '0;
          best_num      = '0;
          best_node     = '0;
          own_value     = e.value;
          cur_round     = e.round;
          phase         = PH_ONE;
          elapsed       = '0;
          send_msg(KIND_PHASE1, e.round, '0, 1'b1);
          return 1'b1;
        end
        ACT_PROMISE: begin
          if (phase != PH_ONE || !is_ours(e.reply_number, e.reply_node) ||
              int'(e.origin_node) >= NODE_COUNT || promise_seen[e.origin_node])
            return 1'b0;
          promise_seen[e.origin_node] = 1'b1;
          promise_tally = promise_tally + 5'd1;
          // strictly greater replaces, number first, then node
          if (e.has_accepted && (e.accepted_number > best_num ||
              (e.accepted_number == best_num && e.accepted_node > best_node))) begin
            best_num  = e.accepted_number;
            best_node = e.accepted_node;
            chosen    = e.value;
          end
          if (promise_tally >= cfg.quorum) begin
            if (best_num == '0) chosen = own_value;
            phase   = PH_TWO;
            elapsed = '0;
            send_msg(KIND_PHASE2, cur_round, chosen, 1'b1);
          end
          return 1'b1;
        end
        ACT_ACCEPT: begin
          if (phase != PH_TWO || !is_ours(e.reply_number, e.reply_node) ||
              int'(e.origin_node) >= NODE_COUNT || accept_seen[e.origin_node])
            return 1'b0;
          accept_seen[e.origin_node] = 1'b1;
          accept_tally = accept_tally + 5'd1;
          // commit only on the exact quorum count
          if (accept_tally == cfg.quorum) begin
            phase   = PH_PROC;
            elapsed = '0;
            send_msg(KIND_COMMIT, cur_round, chosen, 1'b0);
            send_msg(KIND_CATCHUP, cur_round, chosen, 1'b1);
          end
          return 1'b1;
        end
        ACT_REJECT: begin
          if (phase != PH_ONE || !is_ours(e.reply_number, e.reply_node)) return 1'b0;
          phase   = PH_IDLE;
          elapsed = '0;
          send_msg(KIND_CATCHUP, e.round, e.value, 1'b1);
          return 1'b1;
        end
        ACT_TICK: begin
          if (phase != PH_ONE && phase != PH_TWO) return 1'b0;
          if (elapsed != TICKS_MAX) elapsed = elapsed + 16'd1;
          if (elapsed >= cfg.timeout_ticks) begin
            phase   = PH_IDLE;
            elapsed = '0;
            send_msg(KIND_TIMEOUT, cur_round, '0, 1'b1);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // compare one result transaction with the oldest pending message
    function void match_message(res_t got, time stamp);
      res_t want;
      if (outgoing.size() == 0) begin
        $display("%0t: unexpected message kind %0d round %0h value %0h",
                 stamp, got.kind, got.msg_round, got.msg_value);
        errors++;
        return;
      end
      want = outgoing.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", stamp, want.kind, got.kind);
        errors++;
      end
      if (got.msg_round !== want.msg_round) begin
        $display("%0t: msg_round expected %0h actual %0h", stamp, want.msg_round,
                 got.msg_round);
        errors++;
      end
      if (got.msg_number !== want.msg_number) begin
        $display("%0t: msg_number expected %0h actual %0h", stamp, want.msg_number,
                 got.msg_number);
        errors++;
      end
      if (got.msg_node !== want.msg_node) begin
        $display("%0t: msg_node expected %0h actual %0h", stamp, want.msg_node,
                 got.msg_node);
        errors++;
      end
      if (got.msg_value !== want.msg_value) begin
        $display("%0t: msg_value expected %0h actual %0h", stamp, want.msg_value,
                 got.msg_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", stamp, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// top-level testbench of the paxos proposer engine: directed and random event traffic
// depends on paxp_pkg, paxp_sb_pkg, both channel interfaces and paxos_proposer_engine_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import paxp_pkg::*;
  import paxp_sb_pkg::*;

  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_BLOCKY} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  paxp_evt_if evt_ch();
  paxp_res_if res_ch();

  proposer_tracker sb = new();

  int       burst_left       = 0;
  int       idle_cycles      = 0;
  int       rx_cycle         = 0;
  int       stall_left       = 0;
  rx_mode_t rx_mode          = RX_OPEN;

  paxos_proposer_engine_top #(.NODES(NODE_COUNT)) u_top (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side backpressure, mode re-picked at random periodically
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   res_ch.ready = 1'b1;
        RX_CHOPPY: res_ch.ready = ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left   = $urandom_range(1, 12);
            res_ch.ready = 1'b0;
          end else begin
            res_ch.ready = 1'b1;
          end
        end
      endcase
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin : monitor
    res_t got;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind       = kind_t'(res_ch.kind);
        got.msg_round  = res_ch.msg_round;
        got.msg_number = res_ch.msg_number;
        got.msg_node   = res_ch.msg_node;
        got.msg_value  = res_ch.msg_value;
        got.last       = res_ch.last;
        sb.match_message(got, $time);
      end
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // present one event and hold it until the transaction completes
  task automatic drive_event(evt_t e);
    @(negedge clk);
    evt_ch.action          = e.action;
    evt_ch.round           = e.round;
    evt_ch.value           = e.value;
    evt_ch.reply_number    = e.reply_number;
    evt_ch.reply_node      = e.reply_node;
    evt_ch.origin_node     = e.origin_node;
    evt_ch.has_accepted    = e.has_accepted;
    evt_ch.accepted_number = e.accepted_number;
    evt_ch.accepted_node   = e.accepted_node;
    evt_ch.valid           = 1'b1;
    do @(posedge clk); while (evt_ch.ready !== 1'b1);
    void'(sb.take_event(e));
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    if (gap == 0) return;
    @(negedge clk) evt_ch.valid = 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // stop sending until every pending message has come out
  task automatic wait_idle();
    @(negedge clk) evt_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [4:0] q, logic [3:0] own, logic [15:0] ticks);
    wait_idle();
    poke_reg(CFG_QUORUM, CFG_DATA_W'(q));
    poke_reg(CFG_OWN, CFG_DATA_W'(own));
    poke_reg(CFG_TIMEOUT, ticks);
    @(negedge clk) cfg_we = 1'b0;
  endtask

  function automatic evt_t noise_event();
    evt_t e;
    e.action          = 3'($urandom_range(ACT_START, ACT_SPARE_HI));
    e.round           = $urandom;
    e.value           = {$urandom, $urandom};
    e.reply_number    = $urandom;
    e.reply_node      = 4'($urandom);
    e.origin_node     = 4'($urandom);
    e.has_accepted    = 1'($urandom);
    e.accepted_number = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
    e.accepted_node   = 4'($urandom);
    return e;
  endfunction

  function automatic evt_t reply_to(act_t a);
    evt_t e;
    e              = noise_event();
    e.action       = a;
    e.reply_number = sb.counter;
    e.reply_node   = sb.cfg.own_node;
    return e;
  endfunction

  // reply carrying some other proposal
  function automatic evt_t stale_reply(act_t a);
    evt_t e;
    e = reply_to(a);
    if ($urandom_range(0, 1)) e.reply_number = e.reply_number + 32'($urandom_range(1, 3));
    else e.reply_node = e.reply_node ^ 4'($urandom_range(1, 15));
    return e;
  endfunction

  // mostly well-formed traffic for the phase the proposer is in
  function automatic evt_t pick_event();
    evt_t e;
    int   r;
    e = noise_event();
    r = $urandom_range(0, 99);
    case (sb.phase)
      PH_ONE: begin
        if (r < 66) e = reply_to(ACT_PROMISE);
        else if (r < 74) e = stale_reply(ACT_PROMISE);
        else if (r < 76 && sb.cfg.quorum <= 5'd8) e = reply_to(ACT_REJECT);
        else if (r < 79) e = stale_reply(ACT_REJECT);
        else if (r < 90) e.action = ACT_TICK;
        else if (r < 93) e = reply_to(ACT_ACCEPT);
        else if (r < 95) e.action = ACT_START;
      end
      PH_TWO: begin
        if (r < 66) e = reply_to(ACT_ACCEPT);
        else if (r < 74) e = stale_reply(ACT_ACCEPT);
        else if (r < 85) e.action = ACT_TICK;
        else if (r < 89) e = reply_to(ACT_PROMISE);
        else if (r < 92) e = reply_to(ACT_REJECT);
        else if (r < 95) e.action = ACT_START;
      end
      default: begin
        if (r < 60) e.action = ACT_START;
        else if (r < 72) e.action = ACT_TICK;
        else if (r < 78) e = reply_to(ACT_PROMISE);
        else if (r < 84) e = reply_to(ACT_ACCEPT);
        else if (r < 90) e = reply_to(ACT_REJECT);
      end
    endcase
    return e;
  endfunction

  task automatic send_action(logic [2:0] a);
    evt_t e;
    e        = noise_event();
    e.action = a;
    drive_event(e);
  endtask

  task automatic send_start(logic [31:0] rnd, logic [63:0] v);
    evt_t e;
    e        = noise_event();
    e.action = ACT_START;
    e.round  = rnd;
    e.value  = v;
    drive_event(e);
  endtask

  task automatic send_reply(act_t a, logic [3:0] origin, logic has, logic [31:0] anum,
                            logic [3:0] anode, logic [63:0] v);
    evt_t e;
    e                 = reply_to(a);
    e.origin_node     = origin;
    e.has_accepted    = has;
    e.accepted_number = anum;
    e.accepted_node   = anode;
    e.value           = v;
    drive_event(e);
  endtask

  task automatic directed_events();
    evt_t e;
    // unknown actions and replies or ticks while idle
    send_action(ACT_SPARE_LO);
    send_action(ACT_SPARE_HI);
    send_reply(ACT_PROMISE, 4'd2, 1'b1, 32'd9, 4'd1, 64'd5);
    send_action(ACT_TICK);
    // full round: zero-numbered accepted proposal still falls back to own value
    send_start('1, '1);
    send_reply(ACT_PROMISE, 4'd0, 1'b1, 32'd0, 4'd5, 64'h0123_4567_89ab_cdef);
    send_reply(ACT_PROMISE, 4'd0, 1'b0, 32'd7, 4'd7, 64'd1);
    e              = reply_to(ACT_PROMISE);
    e.reply_number = sb.counter + 32'd1;
    e.origin_node  = 4'd1;
    drive_event(e);
    send_reply(ACT_PROMISE, 4'd15, 1'b0, '1, 4'd15, '0);
    // promise and reject in phase two are ignored
    send_reply(ACT_PROMISE, 4'd6, 1'b1, 32'd99, 4'd3, 64'd6);
    send_reply(ACT_REJECT, 4'd6, 1'b0, 32'd0, 4'd0, 64'd6);
    send_reply(ACT_ACCEPT, 4'd15, 1'b0, 32'd0, 4'd0, '0);
    send_reply(ACT_ACCEPT, 4'd15, 1'b0, 32'd0, 4'd0, '0);
    drive_event(stale_reply(ACT_ACCEPT));
    send_reply(ACT_ACCEPT, 4'd0, 1'b0, 32'd0, 4'd0, '1);
    // waiting after commit
    send_reply(ACT_ACCEPT, 4'd3, 1'b0, 32'd0, 4'd0, '0);
    send_action(ACT_TICK);
    // equal best proposals keep the first value
    send_start('0, '0);
    send_reply(ACT_PROMISE, 4'd3, 1'b1, 32'd5, 4'd2, 64'haaaa_5555_aaaa_5555);
    send_reply(ACT_PROMISE, 4'd4, 1'b1, 32'd5, 4'd2, 64'h5555_aaaa_5555_aaaa);
    send_action(ACT_TICK);
    // reject in phase one
    send_start(32'h1234_5678, 64'hfeed_0000_beef_0000);
    drive_event(stale_reply(ACT_REJECT));
    send_reply(ACT_REJECT, 4'd9, 1'b1, '1, 4'd15, '1);
    send_reply(ACT_REJECT, 4'd9, 1'b0, '0, 4'd0, '1);
  endtask

  task automatic run_traffic(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      drive_event(pick_event());
      sent++;
      pace();
      if ($urandom_range(0, 149) == 0) wait_idle();
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    evt_ch.valid           = 1'b0;
    evt_ch.action          = '0;
    evt_ch.round           = '0;
    evt_ch.value           = '0;
    evt_ch.reply_number    = '0;
    evt_ch.reply_node      = '0;
    evt_ch.origin_node     = '0;
    evt_ch.has_accepted    = 1'b0;
    evt_ch.accepted_number = '0;
    evt_ch.accepted_node   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    directed_events();

    // extremes first, then a few random settings
    configure(5'd1, 4'd15, 16'd1);
    run_traffic(110);
    configure(5'd16, 4'd7, 16'hFFFF);
    run_traffic(200);
    configure(5'd0, 4'd3, 16'd0);
    run_traffic(70);
    repeat (3) begin
      configure(5'($urandom_range(1, 5)), 4'($urandom), 16'($urandom_range(2, 12)));
      run_traffic(110);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
